### rtl/assert_macros.svh
// Assertion macros shared by the sampler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every cycle out of reset.
`define CHECK_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");

// Same-cycle implication.
`define CHECK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/dics_pkg.sv
// Types and constants shared by the inverse-CDF sampler modules.
package dics_pkg;

  // Fixed field widths of the item and result ports
  localparam int BIN_IDX_W = 9;
  localparam int FIELD_W   = 16;
  localparam int CFG_W     = 10;
  localparam int WAVE_W    = 11;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_BASE_WAVELENGTH = 2'd0;
  localparam logic [1:0] REG_BIN_COUNT       = 2'd1;
  localparam logic [1:0] REG_PRODUCT_MODE    = 2'd2;

  localparam logic [CFG_W-1:0] BASE_WAVELENGTH_RESET = 10'd360;
  localparam logic [CFG_W-1:0] BIN_COUNT_RESET       = 10'd471;
  localparam logic             PRODUCT_MODE_RESET    = 1'b1;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [BIN_IDX_W-1:0] bin_index;
    logic [FIELD_W-1:0]   weight_first;
    logic [FIELD_W-1:0]   weight_second;
    logic [FIELD_W-1:0]   u_fraction;
  } cmd_t;

  // Back-end status seen by the front end
  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_SUM    = 3'd2,
    ST_MUL    = 3'd3,
    ST_THR    = 3'd4,
    ST_SEARCH = 3'd5,
    ST_OUT    = 3'd6
  } back_state_t;

endpackage

### rtl/dics_front.sv
// Front end: accepts items, classifies them and queues commands for the back end.
module dics_front
  import dics_pkg::*;
#(
  parameter int MAX_BINS = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 action,
  input  logic [BIN_IDX_W-1:0] bin_index,
  input  logic [FIELD_W-1:0]   weight_first,
  input  logic [FIELD_W-1:0]   weight_second,
  input  logic [FIELD_W-1:0]   u_fraction,
  input  back_status_t         status,
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  input  logic                 cmd_ready
);

  `include "assert_macros.svh"

  cmd_t                  fifo [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  accept;
  logic                  drop;
  logic                  wr;
  logic                  rd;
  cmd_t                  incoming;

  // Classify: loads past the table end are taken and discarded
  always_comb begin
    incoming.kind          = action ? CMD_SAMPLE : CMD_LOAD;
    incoming.bin_index     = bin_index;
    incoming.weight_first  = weight_first;
    incoming.weight_second = weight_second;
    incoming.u_fraction    = u_fraction;
  end

  assign full   = (count == FIFO_CNT_W'(FIFO_DEPTH)) || status.clearing;
  assign accept = push && !full;
  assign drop   = (incoming.kind == CMD_LOAD) && (int'(bin_index) >= MAX_BINS);
  assign wr     = accept && !drop;
  assign rd     = cmd_valid && cmd_ready;

  assign cmd_valid = (count != '0);
  assign cmd       = fifo[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr) begin
      fifo[wr_ptr] <= incoming;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `CHECK_ALWAYS(a_count_bound, clk, rst, count <= FIFO_CNT_W'(FIFO_DEPTH))
  `CHECK_ALWAYS(a_count_step, clk, rst, (count == $past(count)) || (count == $past(count) + 1'b1) || (count == $past(count) - 1'b1))

endmodule

### rtl/dics_back.sv
// Back end: weight memory, total and search sweeps, threshold multiply, result register.
module dics_back
  import dics_pkg::*;
#(
  parameter int MAX_BINS    = 512,
  parameter int WEIGHT_BITS = 16,
  parameter int U_BITS      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_ready,
  output back_status_t      status,
  input  logic [CFG_W-1:0]  base_wavelength,
  input  logic [CFG_W-1:0]  bin_count,
  input  logic              product_mode,
  output logic              out_valid,
  input  logic              pop,
  output logic [WAVE_W-1:0] wavelength,
  output logic              zero_total
);

  `include "assert_macros.svh"

  localparam int IDX_W  = $clog2(MAX_BINS);
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int W_W    = (WEIGHT_BITS < FIELD_W) ? WEIGHT_BITS : FIELD_W;
  localparam int U_W    = (U_BITS < FIELD_W) ? U_BITS : FIELD_W;
  localparam int PW     = 2 * W_W;
  localparam int SUM_W  = PW + IDX_W;
  localparam int PROD_W = SUM_W + U_W;
  localparam int BIT_W  = $clog2(U_W);

  back_state_t state, state_next;

  // Weight memory: {first, second} per bin
  logic [PW-1:0]    mem [MAX_BINS];
  logic [PW-1:0]    rdata;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [PW-1:0]    wr_data;
  logic [IDX_W-1:0] clr_ptr;

  // Sample context
  logic [CNT_W-1:0] n_bins;
  logic [CNT_W-1:0] n_bins_next;
  logic             mode;
  logic [U_W-1:0]   u_val;

  // Sweep pipeline
  logic [CNT_W-1:0] issue_idx;
  logic             issue;
  logic             v1, v2;
  logic [IDX_W-1:0] idx1, idx2;
  logic [PW-1:0]    weight;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] cum_next;
  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] thr;
  logic [PROD_W-1:0] prod;
  logic [BIT_W-1:0] mul_bit;
  logic             drained;
  logic             found;

  // Result
  logic [IDX_W-1:0] res_bin;
  logic             res_zero;

  // Control strobes
  logic load_wr;
  logic start_sample;
  logic sum_done;
  logic search_miss;
  logic out_load;

  assign status.clearing = (state == ST_CLEAR);

  // Effective bin count: zero acts as one, clamp to table size
  always_comb begin
    if (int'(bin_count) > MAX_BINS) begin
      n_bins_next = CNT_W'(MAX_BINS);
    end else if (bin_count == '0) begin
      n_bins_next = CNT_W'(1);
    end else begin
      n_bins_next = CNT_W'(bin_count);
    end
  end

  assign issue    = ((state == ST_SUM) || (state == ST_SEARCH)) && (issue_idx < n_bins) && !found;
  assign drained  = (issue_idx == n_bins) && !v1 && !v2;
  assign cum_next = acc + SUM_W'(weight);
  assign found    = (state == ST_SEARCH) && v2 && (cum_next >= thr);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes
  always_comb begin
    state_next   = state;
    cmd_ready    = 1'b0;
    load_wr      = 1'b0;
    start_sample = 1'b0;
    sum_done     = 1'b0;
    search_miss  = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_ptr == IDX_W'(MAX_BINS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd.kind == CMD_SAMPLE) begin
            start_sample = 1'b1;
            state_next   = ST_SUM;
          end else begin
            load_wr = 1'b1;
          end
        end
      end
      ST_SUM: begin
        if (drained) begin
          sum_done   = 1'b1;
          state_next = (acc == '0) ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_bit == '0) begin
          state_next = ST_THR;
        end
      end
      ST_THR: begin
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (found) begin
          state_next = ST_OUT;
        end else if (drained) begin
          search_miss = 1'b1;
          state_next  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Memory write: clearing pass or load command
  always_comb begin
    wr_en   = status.clearing || load_wr;
    wr_addr = status.clearing ? clr_ptr : IDX_W'(cmd.bin_index);
    wr_data = status.clearing ? '0 :
              {cmd.weight_first[W_W-1:0], cmd.weight_second[W_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[issue_idx[IDX_W-1:0]];
  end

  // Clearing pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (status.clearing) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  // Sweep valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1 && !found;
    end
  end

  // Sweep datapath: read, weigh, accumulate
  always_ff @(posedge clk) begin
    idx1 <= issue_idx[IDX_W-1:0];
    idx2 <= idx1;
    if (mode) begin
      weight <= PW'(rdata[PW-1:W_W]) * PW'(rdata[W_W-1:0]);
    end else begin
      weight <= PW'(rdata[PW-1:W_W]);
    end

    if (start_sample) begin
      n_bins    <= n_bins_next;
      mode      <= product_mode;
      u_val     <= cmd.u_fraction[U_W-1:0];
      issue_idx <= '0;
      acc       <= '0;
    end else if (sum_done) begin
      total     <= acc;
      acc       <= '0;
      issue_idx <= '0;
    end else begin
      if (issue) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (v2 && (state == ST_SUM || state == ST_SEARCH)) begin
        acc <= cum_next;
      end
    end
  end

  // Threshold: ceil(u * total / 2^U_BITS), u * total by shift-add from the top bit
  always_ff @(posedge clk) begin
    if (sum_done) begin
      prod    <= '0;
      mul_bit <= BIT_W'(U_W - 1);
    end else if (state == ST_MUL) begin
      prod    <= {prod[PROD_W-2:0], 1'b0} + (u_val[mul_bit] ? PROD_W'(total) : '0);
      mul_bit <= mul_bit - 1'b1;
    end
    if (state == ST_THR) begin
      thr <= SUM_W'((prod >> U_BITS) + PROD_W'(|prod[U_BITS-1:0]));
    end
  end

  // Selected bin
  always_ff @(posedge clk) begin
    if (sum_done && (acc == '0)) begin
      res_bin  <= '0;
      res_zero <= 1'b1;
    end else if (found) begin
      res_bin  <= idx2;
      res_zero <= 1'b0;
    end else if (search_miss) begin
      res_bin  <= IDX_W'(n_bins - 1'b1);
      res_zero <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      wavelength <= WAVE_W'(base_wavelength) + WAVE_W'(res_bin);
      zero_total <= res_zero;
    end
  end

  `CHECK_IMPLY(a_search_nonzero, clk, rst, state == ST_SEARCH, total != '0)
  `CHECK_IMPLY(a_thr_bound, clk, rst, state == ST_SEARCH, thr <= total)
  `CHECK_IMPLY(a_read_in_range, clk, rst, v1, CNT_W'(idx1) < n_bins)

endmodule

### rtl/discrete_inverse_cdf_sampler_unit.sv
// Top level of the discrete inverse-CDF wavelength sampler.
// Draws a bin from the loaded weight tables by inverse transform sampling and
// returns base_wavelength plus that bin. Load items (action 0) write one bin of
// both weight tables in the back end. Sample items (action 1) make two sweeps
// over the single read port of the weight memory (one for the total, one for the
// search) and, between them, a shift-add multiply of u by the total, one bit per
// cycle; at most 16 bits of u are used, min(U_BITS,16). A four-deep command
// queue takes items while the back end works, and a result register holds a
// finished result until popped. After reset the weight memory is cleared one
// bin per cycle, during which full is high; configuration writes are taken
// throughout.
module discrete_inverse_cdf_sampler_unit
  import dics_pkg::*;
#(
  parameter int MAX_BINS    = 512,
  parameter int WEIGHT_BITS = 16,
  parameter int U_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // item input
  input  logic                  push,
  output logic                  full,
  input  logic                  action,
  input  logic [BIN_IDX_W-1:0]  bin_index,
  input  logic [FIELD_W-1:0]    weight_first,
  input  logic [FIELD_W-1:0]    weight_second,
  input  logic [FIELD_W-1:0]    u_fraction,
  // result output
  output logic                  empty,
  input  logic                  pop,
  output logic [WAVE_W-1:0]     wavelength,
  output logic                  zero_total,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_W-1:0] base_wavelength;
  logic [CFG_W-1:0] bin_count;
  logic             product_mode;
  logic             cfg_wr;
  logic [1:0]       reg_sel;

  logic         cmd_valid;
  logic         cmd_ready;
  cmd_t         cmd;
  back_status_t status;
  logic         out_valid;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_wavelength <= BASE_WAVELENGTH_RESET;
      bin_count       <= BIN_COUNT_RESET;
      product_mode    <= PRODUCT_MODE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BASE_WAVELENGTH: base_wavelength <= pwdata[CFG_W-1:0];
        REG_BIN_COUNT:       bin_count       <= pwdata[CFG_W-1:0];
        REG_PRODUCT_MODE:    product_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_sel)
      REG_BASE_WAVELENGTH: prdata = APB_DATA_W'(base_wavelength);
      REG_BIN_COUNT:       prdata = APB_DATA_W'(bin_count);
      REG_PRODUCT_MODE:    prdata = APB_DATA_W'(product_mode);
      default:             prdata = '0;
    endcase
  end

  dics_front #(
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .bin_index     (bin_index),
    .weight_first  (weight_first),
    .weight_second (weight_second),
    .u_fraction    (u_fraction),
    .status        (status),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_ready     (cmd_ready)
  );

  dics_back #(
    .MAX_BINS    (MAX_BINS),
    .WEIGHT_BITS (WEIGHT_BITS),
    .U_BITS      (U_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_ready       (cmd_ready),
    .status          (status),
    .base_wavelength (base_wavelength),
    .bin_count       (bin_count),
    .product_mode    (product_mode),
    .out_valid       (out_valid),
    .pop             (pop),
    .wavelength      (wavelength),
    .zero_total      (zero_total)
  );

  assign empty = !out_valid;

endmodule

### tb/dics_draw_checker.sv
// Checker for the inverse-CDF sampler: mirrors the weight tables, predicts each draw, compares.
module dics_draw_checker
  import dics_pkg::*;
#(
  parameter int MAX_BINS = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  logic                  action,
  input  logic [BIN_IDX_W-1:0]  bin_index,
  input  logic [FIELD_W-1:0]    weight_first,
  input  logic [FIELD_W-1:0]    weight_second,
  input  logic [FIELD_W-1:0]    u_fraction,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [WAVE_W-1:0]     wavelength,
  input  logic                  zero_total,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    draws_pending
);

  typedef struct packed {
    logic [WAVE_W-1:0] wave;
    logic              zero;
  } draw_t;

  // Shadow copy of the weight tables and registers
  logic [FIELD_W-1:0] first_tbl  [MAX_BINS];
  logic [FIELD_W-1:0] second_tbl [MAX_BINS];
  logic [CFG_W-1:0]   base_reg;
  logic [CFG_W-1:0]   count_reg;
  logic               prod_reg;

  draw_t expected_draws[$];
  int    fail_tally = 0;

  function automatic logic [63:0] bin_weight(int i);
    logic [63:0] w;
    w = 64'(first_tbl[i]);
    if (prod_reg) w = w * 64'(second_tbl[i]);
    return w;
  endfunction

  // First bin whose running sum times 2^16 reaches u times the total
  function automatic draw_t predict_draw(logic [FIELD_W-1:0] u);
    int          n;
    int          i;
    int          chosen;
    logic        found;
    logic [63:0] total;
    logic [63:0] cum;
    logic [63:0] target;
    draw_t       d;
    n = int'(count_reg);
    if (n == 0) n = 1;
    if (n > MAX_BINS) n = MAX_BINS;
    total = '0;
    for (i = 0; i < n; i++) total += bin_weight(i);
    if (total == 0) begin
      d.wave = WAVE_W'(base_reg);
      d.zero = 1'b1;
      return d;
    end
    target = 64'(u) * total;
    cum    = '0;
    chosen = n - 1;
    found  = 1'b0;
    for (i = 0; i < n && !found; i++) begin
      cum += bin_weight(i);
      if ((cum << FIELD_W) >= target) begin
        chosen = i;
        found  = 1'b1;
      end
    end
    d.wave = WAVE_W'(base_reg) + WAVE_W'(chosen);
    d.zero = 1'b0;
    return d;
  endfunction

  task automatic report(input string msg);
    $display("%0t draw check: %s", $time, msg);
    fail_tally++;
  endtask

  always @(posedge clk) begin : watch
    int    k;
    draw_t want;
    if (rst) begin
      for (k = 0; k < MAX_BINS; k++) begin
        first_tbl[k]  = '0;
        second_tbl[k] = '0;
      end
      base_reg  = BASE_WAVELENGTH_RESET;
      count_reg = BIN_COUNT_RESET;
      prod_reg  = PRODUCT_MODE_RESET;
      expected_draws.delete();
    end else begin
      // register writes; unmapped addresses are dropped
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BASE_WAVELENGTH: base_reg  = pwdata[CFG_W-1:0];
          REG_BIN_COUNT:       count_reg = pwdata[CFG_W-1:0];
          REG_PRODUCT_MODE:    prod_reg  = pwdata[0];
          default: ;
        endcase
      end
      // results leaving the block
      if (pop && !empty) begin
        if (expected_draws.size() == 0) begin
          report($sformatf("unexpected item wavelength=%0d zero_total=%0b",
                           wavelength, zero_total));
        end else begin
          want = expected_draws.pop_front();
          if (wavelength !== want.wave)
            report($sformatf("wavelength %0d, want %0d", wavelength, want.wave));
          if (zero_total !== want.zero)
            report($sformatf("zero_total %0b, want %0b", zero_total, want.zero));
        end
      end
      // items entering the block
      if (push && !full) begin
        if (action == CMD_LOAD) begin
          if (int'(bin_index) < MAX_BINS) begin
            first_tbl[bin_index]  = weight_first;
            second_tbl[bin_index] = weight_second;
          end
        end else begin
          expected_draws.push_back(predict_draw(u_fraction));
        end
      end
    end
    mismatches    <= fail_tally;
    draws_pending <= expected_draws.size();
  end

endmodule

### tb/testbench.sv
// Top of the sampler testbench: clock, reset, item and register stimulus, verdict.
module testbench;
  import dics_pkg::*;

  localparam int          SETTLE       = 64;
  localparam logic [1:0]  REG_UNMAPPED = 2'd3;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  push          = 1'b0;
  logic                  full;
  logic                  action        = CMD_LOAD;
  logic [BIN_IDX_W-1:0]  bin_index     = '0;
  logic [FIELD_W-1:0]    weight_first  = '0;
  logic [FIELD_W-1:0]    weight_second = '0;
  logic [FIELD_W-1:0]    u_fraction    = '0;
  logic                  empty;
  logic                  pop           = 1'b0;
  logic [WAVE_W-1:0]     wavelength;
  logic                  zero_total;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int draws_pending;
  bit tx_steady = 1'b1;
  bit rx_steady = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  discrete_inverse_cdf_sampler_unit u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .action(action), .bin_index(bin_index),
    .weight_first(weight_first), .weight_second(weight_second),
    .u_fraction(u_fraction),
    .empty(empty), .pop(pop), .wavelength(wavelength), .zero_total(zero_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dics_draw_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .action(action), .bin_index(bin_index),
    .weight_first(weight_first), .weight_second(weight_second),
    .u_fraction(u_fraction),
    .empty(empty), .pop(pop), .wavelength(wavelength), .zero_total(zero_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .draws_pending(draws_pending)
  );

  // Hand one item over; push stays high if the next item follows at once
  task automatic send_item(input cmd_kind_t kind, input logic [BIN_IDX_W-1:0] idx,
                           input logic [FIELD_W-1:0] wf, input logic [FIELD_W-1:0] ws,
                           input logic [FIELD_W-1:0] u);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    action        <= kind;
    bin_index     <= idx;
    weight_first  <= wf;
    weight_second <= ws;
    u_fraction    <= u;
    do @(posedge clk); while (full);
  endtask

  task automatic send_load(input logic [BIN_IDX_W-1:0] idx, input logic [FIELD_W-1:0] wf,
                           input logic [FIELD_W-1:0] ws);
    send_item(CMD_LOAD, idx, wf, ws, FIELD_W'($urandom()));
  endtask

  task automatic send_sample(input logic [FIELD_W-1:0] u);
    send_item(CMD_SAMPLE, BIN_IDX_W'($urandom()), FIELD_W'($urandom()),
              FIELD_W'($urandom()), u);
  endtask

  // Hold off until every draw is back and trailing loads have drained
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (draws_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Unused upper data bits carry noise; the block must ignore them
  task automatic set_config(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] count,
                            input logic mode);
    logic [APB_DATA_W-1:0] word;
    wait_drained();
    word = $urandom();
    word[CFG_W-1:0] = base;
    write_reg(REG_BASE_WAVELENGTH, word);
    word = $urandom();
    word[CFG_W-1:0] = count;
    write_reg(REG_BIN_COUNT, word);
    word = $urandom();
    word[0] = mode;
    write_reg(REG_PRODUCT_MODE, word);
  endtask

  function automatic logic [FIELD_W-1:0] pick_weight();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) return '0;
    if (sel < 5) return '1;
    if (sel < 9) return FIELD_W'($urandom_range(0, 255));
    return FIELD_W'($urandom());
  endfunction

  function automatic logic [FIELD_W-1:0] pick_u();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return FIELD_W'($urandom());
  endfunction

  // Result side: random stalls with steady stretches
  initial begin : drain_results
    int stall;
    int taken;
    taken = 0;
    do @(posedge clk); while (rst);
    stall = $urandom_range(0, 18);
    forever begin
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
      if (taken % 25 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, 18);
    end
  end

  initial begin : stimulus
    int                 ph;
    int                 k;
    int                 sel;
    int                 used;
    logic [CFG_W-1:0]   count;
    logic [CFG_W-1:0]   base;
    logic [BIN_IDX_W-1:0] idx;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings with empty tables give the zero-total flag
    send_sample('0);
    send_sample('1);

    // four bins, outer two loaded, load beyond the bins in use
    set_config(10'd1023, 10'd4, 1'b1);
    send_load(9'd0, '1, '1);
    send_load(9'd3, '1, '1);
    send_load(9'd511, 16'd1, 16'd1);
    send_sample('0);
    send_sample(16'h8000);          // running sum lands exactly on the threshold
    send_sample('1);
    send_load(9'd0, '1, '0);        // product weight of zero
    send_sample('0);
    send_sample(16'd1);

    // first table only
    set_config(10'd0, 10'd4, 1'b0);
    send_sample(16'h8000);
    send_sample(16'h8001);
    send_load(9'd1, '0, '1);
    send_sample('1);

    // bin count zero acts as one
    set_config(10'd512, 10'd0, 1'b1);
    send_sample(16'h1234);
    send_load(9'd0, 16'd1, 16'd1);
    send_sample('1);

    // bin count beyond the table, largest base
    set_config(10'd1023, 10'd1023, 1'b1);
    send_load(9'd511, '1, '1);
    send_sample('1);
    send_sample('0);

    // write to an address past the register list is dropped
    wait_drained();
    write_reg(REG_UNMAPPED, $urandom());
    set_config(10'd0, 10'd512, 1'b1);
    send_sample(16'h4000);
    send_load(9'd256, 16'h00FF, 16'hFF00);
    send_sample(16'hAAAA);

    // random phases, mostly small bin counts
    for (ph = 0; ph < 14; ph++) begin
      if (ph == 4) begin
        count = 10'd471;
      end else if (ph == 10) begin
        count = 10'd512;
      end else begin
        sel = $urandom_range(0, 7);
        if (sel == 0) count = '0;
        else if (sel == 1) count = CFG_W'($urandom_range(17, 64));
        else count = CFG_W'($urandom_range(1, 16));
      end
      sel = $urandom_range(0, 5);
      if (sel == 0) base = '0;
      else if (sel == 1) base = '1;
      else base = CFG_W'($urandom());
      set_config(base, count, 1'($urandom_range(0, 1)));
      used = (count == 0) ? 1 : int'(count);
      tx_steady = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 40; k++) begin
        if ($urandom_range(0, 9) < 4) begin
          send_sample(pick_u());
        end else begin
          if ($urandom_range(0, 6) == 0) idx = BIN_IDX_W'($urandom());
          else idx = BIN_IDX_W'($urandom_range(0, used - 1));
          send_load(idx, pick_weight(), pick_weight());
        end
      end
    end

    wait_drained();
    if (mismatches == 0 && draws_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #48_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/dics_pkg.sv
rtl/dics_front.sv
rtl/dics_back.sv
rtl/discrete_inverse_cdf_sampler_unit.sv
tb/dics_draw_checker.sv
tb/testbench.sv
